@@ sv/audio_band_envelope_follower_core_macros.svh @@
// assertion macros for the envelope follower block
`ifndef AUDIO_BAND_ENVELOPE_FOLLOWER_CORE_MACROS_SVH
`define AUDIO_BAND_ENVELOPE_FOLLOWER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define ABEF_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// implication checked in the cycle after the condition
`define ABEF_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

@@ sv/abef_pkg.sv @@
// package: payload types, constants and reset values for the envelope follower
`default_nettype none
package abef_pkg;

    localparam int ZONE_COUNT_DEFAULT = 4;

    localparam logic [15:0] BASS_ALPHA_RST     = 16'd10059;
    localparam logic [15:0] TREBLE_ALPHA_RST   = 16'd12321;
    localparam logic [15:0] ATTACK_ALPHA_RST   = 16'd8769;
    localparam logic [15:0] DECAY_ALPHA_RST    = 16'd1083;
    localparam logic [15:0] IMPACT_KEEP_RST    = 16'd62574;
    localparam logic [15:0] FOLLOWER_FLOOR_RST = 16'd2621;

    localparam logic [15:0] PEAK_RESET    = 16'd9830;
    localparam logic [15:0] SNARE_FLOOR   = 16'd52429;
    localparam logic [13:0] SPACING_BASE  = 14'd10486;
    localparam logic [11:0] SPACING_SLOPE = 12'd3932;
    localparam logic [13:0] SPACING_MIN   = 14'd5243;
    localparam logic [13:0] SPACING_MAX   = 14'd13107;
    localparam logic [14:0] SHARP_BASE    = 15'd8192;
    localparam logic [14:0] SHARP_MIN     = 15'd7373;
    localparam logic [14:0] SHARP_MAX     = 15'd16384;
    localparam logic [5:0]  FADE_MIN      = 6'd15;
    localparam logic [5:0]  FADE_MAX      = 6'd60;

    // register indexes
    localparam logic [2:0] REG_BASS_ALPHA     = 3'd0;
    localparam logic [2:0] REG_TREBLE_ALPHA   = 3'd1;
    localparam logic [2:0] REG_ATTACK_ALPHA   = 3'd2;
    localparam logic [2:0] REG_DECAY_ALPHA    = 3'd3;
    localparam logic [2:0] REG_IMPACT_KEEP    = 3'd4;
    localparam logic [2:0] REG_FOLLOWER_FLOOR = 3'd5;

    typedef struct packed {
        logic [2:0]  zone;
        logic        audio_valid;
        logic [15:0] raw_bass;
        logic [15:0] raw_treble;
        logic [15:0] beat_strength;
        logic        snare_hit;
    } in_item_t;

    typedef struct packed {
        logic [15:0] norm_bass;
        logic [15:0] norm_treble;
        logic [15:0] impact_out;
        logic [13:0] cell_spacing;
        logic [14:0] sharpness;
        logic [5:0]  fade_amount;
    } out_item_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [15:0] num;
        logic [15:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quot;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ sv/abef_div.sv @@
// restoring divider: (num << 16) / den saturated to 16 bits, one quotient bit per cycle
`default_nettype none
`include "audio_band_envelope_follower_core_macros.svh"
module abef_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire abef_pkg::div_req_t req,
    output abef_pkg::div_rsp_t     rsp
);

    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] den_reg, den_next;
    logic [15:0] quot_reg, quot_next;
    logic [16:0] shifted;
    logic [16:0] trial;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sat_reg  <= sat_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    // num >= den saturates (a zero numerator gives zero), else 16 steps with rem < den
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        trial     = shifted - {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            rem_next  = req.num;
            den_next  = req.den;
            sat_next  = (req.num >= req.den);
            quot_next = (req.num == 16'd0) ? 16'd0 : 16'hFFFF;
        end
        else if (busy_reg)
        begin
            if (!sat_reg)
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_next  = trial[15:0];
                    quot_next = {quot_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = shifted[15:0];
                    quot_next = {quot_reg[14:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // response
    always_comb
    begin
        rsp.done = done_reg;
        rsp.quot = quot_reg;
    end

    `ABEF_ASSERT_NEXT(a_div_done_after_busy, clk, rst_n, done_reg, !busy_reg)
    `ABEF_ASSERT_IMP(a_div_no_start_busy, clk, rst_n, busy_reg, !req.start)
    `ABEF_ASSERT_IMP(a_div_cnt_idle, clk, rst_n, !busy_reg && !req.start, cnt_next == cnt_reg)

endmodule
`default_nettype wire

@@ sv/audio_band_envelope_follower_core.sv @@
// top level: zone state, register port, sequencer with shared multiplier and divider
// Each item runs through the sequencer in order: five approach updates
// (bass and treble level, both peaks, impact) share one 16x16 multiplier with a registered
// product, then two normalizing divisions share a restoring divider
// (start, 16 quotient bits, done), then S_FIN forms the result and stores the zone,
// and S_IDLE takes the next item. The finished result is registered from S_FIN and
// waits in an output register, so input stall is high only while an item is in work;
// a finished item holds in S_FIN only while the previous result is still stalled.
// Zone state lives in per-zone registers, reset on rst_n.
// Registers: 0 bass_alpha, 1 treble_alpha, 2 attack_alpha, 3 decay_alpha,
// 4 impact_keep, 5 follower_floor, each 16 bits at byte address 4*i.
`default_nettype none
`include "audio_band_envelope_follower_core_macros.svh"
module audio_band_envelope_follower_core
#(
    parameter int ZONE_COUNT = abef_pkg::ZONE_COUNT_DEFAULT
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire abef_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output abef_pkg::out_item_t      out_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [4:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_BL    = 9'b000000010,
        S_TL    = 9'b000000100,
        S_BP    = 9'b000001000,
        S_TP    = 9'b000010000,
        S_IMP   = 9'b000100000,
        S_DIVB  = 9'b001000000,
        S_DIVT  = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] bass_alpha_reg, treble_alpha_reg, attack_alpha_reg;
    logic [15:0] decay_alpha_reg, impact_keep_reg, follower_floor_reg;

    logic [15:0] bl_reg [ZONE_COUNT];
    logic [15:0] tl_reg [ZONE_COUNT];
    logic [15:0] bp_reg [ZONE_COUNT];
    logic [15:0] tp_reg [ZONE_COUNT];
    logic [15:0] im_reg [ZONE_COUNT];

    abef_pkg::in_item_t item_reg;
    logic [ZW-1:0] zsel_reg;
    logic [15:0]   bl_new_reg, tl_new_reg, bp_new_reg, tp_new_reg, im_new_reg;
    logic [15:0]   nb_reg, nt_reg;
    logic          half_reg;
    logic [31:0]   prod_reg;
    abef_pkg::out_item_t res_reg;
    logic          out_valid_reg;

    logic [2:0] reg_idx;
    logic       wr_en;
    logic       accept;
    logic       fin_go;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bass_alpha_reg     <= abef_pkg::BASS_ALPHA_RST;
            treble_alpha_reg   <= abef_pkg::TREBLE_ALPHA_RST;
            attack_alpha_reg   <= abef_pkg::ATTACK_ALPHA_RST;
            decay_alpha_reg    <= abef_pkg::DECAY_ALPHA_RST;
            impact_keep_reg    <= abef_pkg::IMPACT_KEEP_RST;
            follower_floor_reg <= abef_pkg::FOLLOWER_FLOOR_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                abef_pkg::REG_BASS_ALPHA:     bass_alpha_reg     <= pwdata[15:0];
                abef_pkg::REG_TREBLE_ALPHA:   treble_alpha_reg   <= pwdata[15:0];
                abef_pkg::REG_ATTACK_ALPHA:   attack_alpha_reg   <= pwdata[15:0];
                abef_pkg::REG_DECAY_ALPHA:    decay_alpha_reg    <= pwdata[15:0];
                abef_pkg::REG_IMPACT_KEEP:    impact_keep_reg    <= pwdata[15:0];
                abef_pkg::REG_FOLLOWER_FLOOR: follower_floor_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_idx)
            abef_pkg::REG_BASS_ALPHA:     prdata = {16'd0, bass_alpha_reg};
            abef_pkg::REG_TREBLE_ALPHA:   prdata = {16'd0, treble_alpha_reg};
            abef_pkg::REG_ATTACK_ALPHA:   prdata = {16'd0, attack_alpha_reg};
            abef_pkg::REG_DECAY_ALPHA:    prdata = {16'd0, decay_alpha_reg};
            abef_pkg::REG_IMPACT_KEEP:    prdata = {16'd0, impact_keep_reg};
            abef_pkg::REG_FOLLOWER_FLOOR: prdata = {16'd0, follower_floor_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = res_reg;
    // finished item moves to the output register once it is free
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);

    // shared multiplier operand selection and approach step
    logic [15:0] cur_x, cur_t, cur_a, diff, step_res;
    logic        up;
    logic [15:0] beat_in, imp_max;
    logic [15:0] cur_bl, cur_tl, cur_bp, cur_tp, cur_im;

    assign cur_bl = bl_reg[zsel_reg];
    assign cur_tl = tl_reg[zsel_reg];
    assign cur_bp = bp_reg[zsel_reg];
    assign cur_tp = tp_reg[zsel_reg];
    assign cur_im = im_reg[zsel_reg];

    always_comb
    begin
        beat_in = item_reg.audio_valid ? item_reg.beat_strength : 16'd0;
        imp_max = (beat_in > cur_im) ? beat_in : cur_im;
        if (item_reg.audio_valid && item_reg.snare_hit && imp_max < abef_pkg::SNARE_FLOOR)
            imp_max = abef_pkg::SNARE_FLOOR;
        cur_x = 16'd0;
        cur_t = 16'd0;
        cur_a = 16'd0;
        case (state_reg)
            S_BL:
            begin
                cur_x = cur_bl;
                cur_t = item_reg.audio_valid ? item_reg.raw_bass : 16'd0;
                cur_a = bass_alpha_reg;
            end
            S_TL:
            begin
                cur_x = cur_tl;
                cur_t = item_reg.audio_valid ? item_reg.raw_treble : 16'd0;
                cur_a = treble_alpha_reg;
            end
            S_BP:
            begin
                cur_x = cur_bp;
                cur_t = bl_new_reg;
                cur_a = (bl_new_reg > cur_bp) ? attack_alpha_reg : decay_alpha_reg;
            end
            S_TP:
            begin
                cur_x = cur_tp;
                cur_t = tl_new_reg;
                cur_a = (tl_new_reg > cur_tp) ? attack_alpha_reg : decay_alpha_reg;
            end
            S_IMP:
            begin
                cur_x = imp_max;
                cur_t = 16'd0;
                cur_a = impact_keep_reg;
            end
            default: ;
        endcase
        up   = (cur_t >= cur_x);
        diff = up ? (cur_t - cur_x) : (cur_x - cur_t);
        if (state_reg == S_IMP)
            step_res = prod_reg[31:16];
        else if (up)
            step_res = cur_x + prod_reg[31:16];
        else
            step_res = cur_x - prod_reg[31:16];
    end

    // divider
    abef_pkg::div_req_t dreq;
    abef_pkg::div_rsp_t drsp;
    logic div_pend_reg;

    abef_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        dreq.start = 1'b0;
        dreq.num   = bl_new_reg;
        dreq.den   = bp_new_reg;
        if (state_reg == S_DIVB && !div_pend_reg)
            dreq.start = 1'b1;
        if (state_reg == S_DIVT)
        begin
            dreq.num   = tl_new_reg;
            dreq.den   = tp_new_reg;
            dreq.start = !div_pend_reg;
        end
    end

    // derived outputs
    logic [27:0] sp_prod;
    logic [14:0] sp_dec;
    logic [14:0] sp_val;
    logic [18:0] sh_sum;
    logic [16:0] sh_val;
    logic [16:0] inv_nb;
    logic [22:0] fd_prod;
    logic [6:0]  fd_val;
    abef_pkg::out_item_t res_c;

    always_comb
    begin
        sp_prod = {12'd0, nb_reg} * {16'd0, abef_pkg::SPACING_SLOPE};
        sp_dec  = {3'd0, sp_prod[27:16]};
        sp_val  = {1'b0, abef_pkg::SPACING_BASE} - sp_dec;
        sh_sum  = {3'd0, nt_reg} + {2'd0, nt_reg, 1'b0} + {3'd0, im_new_reg};
        sh_val  = {2'd0, abef_pkg::SHARP_BASE} + {3'd0, sh_sum[18:5]};
        inv_nb  = 17'h10000 - {1'b0, nb_reg};
        fd_prod = {6'd0, inv_nb} * 23'd40;
        fd_val  = 7'd20 + {1'b0, fd_prod[21:16]};
        res_c.norm_bass   = nb_reg;
        res_c.norm_treble = nt_reg;
        res_c.impact_out  = im_new_reg;
        if (sp_val < {1'b0, abef_pkg::SPACING_MIN})
            res_c.cell_spacing = abef_pkg::SPACING_MIN;
        else if (sp_val > {1'b0, abef_pkg::SPACING_MAX})
            res_c.cell_spacing = abef_pkg::SPACING_MAX;
        else
            res_c.cell_spacing = sp_val[13:0];
        if (sh_val < {2'd0, abef_pkg::SHARP_MIN})
            res_c.sharpness = abef_pkg::SHARP_MIN;
        else if (sh_val > {2'd0, abef_pkg::SHARP_MAX})
            res_c.sharpness = abef_pkg::SHARP_MAX;
        else
            res_c.sharpness = sh_val[14:0];
        if (fd_val < {1'b0, abef_pkg::FADE_MIN})
            res_c.fade_amount = abef_pkg::FADE_MIN;
        else if (fd_val > {1'b0, abef_pkg::FADE_MAX})
            res_c.fade_amount = abef_pkg::FADE_MAX;
        else
            res_c.fade_amount = fd_val[5:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_BL;
            S_BL:   if (half_reg) state_next = S_TL;
            S_TL:   if (half_reg) state_next = S_BP;
            S_BP:   if (half_reg) state_next = S_TP;
            S_TP:   if (half_reg) state_next = S_IMP;
            S_IMP:  if (half_reg) state_next = S_DIVB;
            S_DIVB: if (drsp.done) state_next = S_DIVT;
            S_DIVT: if (drsp.done) state_next = S_FIN;
            S_FIN:  if (fin_go) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            half_reg      <= 1'b0;
            div_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ZONE_COUNT; i++)
            begin
                bl_reg[i] <= 16'd0;
                tl_reg[i] <= 16'd0;
                bp_reg[i] <= abef_pkg::PEAK_RESET;
                tp_reg[i] <= abef_pkg::PEAK_RESET;
                im_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_BL || state_reg == S_TL || state_reg == S_BP
                || state_reg == S_TP || state_reg == S_IMP)
                half_reg <= !half_reg;
            if (dreq.start)
                div_pend_reg <= 1'b1;
            else if (drsp.done)
                div_pend_reg <= 1'b0;
            // output register: loaded by a finished item, cleared when taken
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            // zone state written back once the item is complete
            if (fin_go)
            begin
                bl_reg[zsel_reg] <= bl_new_reg;
                tl_reg[zsel_reg] <= tl_new_reg;
                bp_reg[zsel_reg] <= bp_new_reg;
                tp_reg[zsel_reg] <= tp_new_reg;
                im_reg[zsel_reg] <= im_new_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            if ({29'd0, in_item.zone} < ZONE_COUNT)
                zsel_reg <= in_item.zone[ZW-1:0];
            else
                zsel_reg <= '0;
        end
        prod_reg <= {16'd0, diff} * {16'd0, cur_a};
        if (half_reg)
        begin
            case (state_reg)
                S_BL:  bl_new_reg <= step_res;
                S_TL:  tl_new_reg <= step_res;
                S_BP:  bp_new_reg <= (step_res < follower_floor_reg) ?
                                     follower_floor_reg : step_res;
                S_TP:  tp_new_reg <= (step_res < follower_floor_reg) ?
                                     follower_floor_reg : step_res;
                S_IMP: im_new_reg <= step_res;
                default: ;
            endcase
        end
        if (state_reg == S_DIVB && drsp.done)
            nb_reg <= drsp.quot;
        if (state_reg == S_DIVT && drsp.done)
            nt_reg <= drsp.quot;
        if (fin_go)
            res_reg <= res_c;
    end

    `ABEF_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    `ABEF_ASSERT_IMP(a_idle_ready, clk, rst_n, state_reg == S_IDLE, !in_stall)
    `ABEF_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, state_reg == S_BL)
    `ABEF_ASSERT_IMP(a_floor_held, clk, rst_n, state_reg == S_DIVB, bp_new_reg >= follower_floor_reg)

endmodule
`default_nettype wire
